FILE: rtl/ftq_pkg.sv
// Shared types and constants for the feedback-paced transmit queue.
package ftq_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned TAG_W  = 16;
    localparam int unsigned DUR_W  = 16;
    localparam int unsigned ENTRY_W = TAG_W + DUR_W;
    localparam int unsigned LIMIT_W = 7;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic [1:0] {
        CMD_ARRIVE  = 2'd0,
        CMD_SERVICE = 2'd1,
        CMD_EMERG   = 2'd2,
        CMD_RXSTAT  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUEUE_LIMIT     = 3'd0,
        REG_FLOW_STEP       = 3'd1,
        REG_CONGESTION_STEP = 3'd2,
        REG_FLOW_HOLD       = 3'd3,
        REG_CONGESTION_HOLD = 3'd4,
        REG_LAG_TOLERANCE   = 3'd5,
        REG_FAILSAFE_FILL   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [LIMIT_W-1:0] queue_limit;
        logic [15:0]        flow_step;
        logic [15:0]        congestion_step;
        logic [TIME_W-1:0]  flow_hold;
        logic [TIME_W-1:0]  congestion_hold;
        logic [15:0]        lag_tolerance;
        logic [15:0]        failsafe_fill;
    } t_cfg;

    typedef struct packed {
        logic              send;
        logic              wake;
        logic              dropped;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] flow_ms;
        logic [TIME_W-1:0] cong_delay;
    } t_s1;

endpackage

FILE: rtl/ftq_cfg.sv
// Configuration register file of the transmit queue.
module ftq_cfg
    import ftq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_QUEUE_LIMIT:     n_cfg.queue_limit     = i_cfg_data[LIMIT_W-1:0];
                REG_FLOW_STEP:       n_cfg.flow_step       = i_cfg_data[15:0];
                REG_CONGESTION_STEP: n_cfg.congestion_step = i_cfg_data[15:0];
                REG_FLOW_HOLD:       n_cfg.flow_hold       = i_cfg_data[TIME_W-1:0];
                REG_CONGESTION_HOLD: n_cfg.congestion_hold = i_cfg_data[TIME_W-1:0];
                REG_LAG_TOLERANCE:   n_cfg.lag_tolerance   = i_cfg_data[15:0];
                REG_FAILSAFE_FILL:   n_cfg.failsafe_fill   = i_cfg_data[15:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.queue_limit     <= LIMIT_W'(64);
            r_cfg.flow_step       <= 16'd25;
            r_cfg.congestion_step <= 16'd25;
            r_cfg.flow_hold       <= TIME_W'(10000);
            r_cfg.congestion_hold <= TIME_W'(10000);
            r_cfg.lag_tolerance   <= 16'd85;
            r_cfg.failsafe_fill   <= 16'd45;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: rtl/ftq_store.sv
// Packet descriptor memory with one write port and a registered read port.
module ftq_store
    import ftq_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned PTR_W = 6
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [PTR_W-1:0]   i_wr_ptr,
    input  logic [ENTRY_W-1:0] i_wr_data,
    input  logic               i_rd_en,
    input  logic [PTR_W-1:0]   i_rd_ptr,
    output logic [ENTRY_W-1:0] o_rd_data
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_ptr];
        end
    end

endmodule

FILE: rtl/ftq_ctrl.sv
// Queue pointers, delay state and first pipeline stage of the transmit queue.
module ftq_ctrl
    import ftq_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned PTR_W = 6,
    parameter int unsigned CNT_W = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [TIME_W-1:0]  i_now_ms,
    input  logic [TAG_W-1:0]   i_pkt_tag,
    input  logic [DUR_W-1:0]   i_pkt_duration,
    input  logic [TIME_W-1:0]  i_rx_count,
    input  logic [15:0]        i_rx_fill,
    input  logic               i_s1_free,
    output logic               o_s1_valid,
    output t_s1                o_s1,
    output logic [CNT_W-1:0]   o_s1_count,
    output logic               o_wr_en,
    output logic [PTR_W-1:0]   o_wr_ptr,
    output logic [ENTRY_W-1:0] o_wr_data,
    output logic               o_rd_en,
    output logic [PTR_W-1:0]   o_rd_ptr
);

    localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic               r_s1_valid;
    t_s1                r_s1;
    logic [CNT_W-1:0]   r_s1_count;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [TIME_W-1:0]  r_flow, n_flow;
    logic [TIME_W-1:0]  r_cong, n_cong;
    logic [TIME_W-1:0]  r_fstamp, n_fstamp;
    logic [TIME_W-1:0]  r_cstamp, n_cstamp;
    logic               r_fstamp_vld, n_fstamp_vld;
    logic               r_cstamp_vld, n_cstamp_vld;
    logic [TIME_W-1:0]  r_sent, n_sent;
    logic               r_pend, n_pend;
    t_s1                n_s1;

    logic               acc;
    logic               push;
    logic [CMP_W-1:0]   limit;
    logic [CMP_W-1:0]   held;
    logic [TIME_W:0]    flow_sum;
    logic [TIME_W:0]    cong_sum;
    logic [TIME_W-1:0]  lag;
    logic               f_exp;
    logic               c_exp;
    t_cmd               cmd;

    assign cmd        = t_cmd'(i_cmd);
    assign o_in_ready = !r_s1_valid || i_s1_free;
    assign acc        = i_in_valid && o_in_ready;
    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;
    assign o_s1_count = r_s1_count;

    assign held  = CMP_W'(r_count);
    assign limit = (CMP_W'(i_cfg.queue_limit) > DEPTH_C) ? DEPTH_C
                                                          : CMP_W'(i_cfg.queue_limit);
    assign push  = acc && (cmd == CMD_ARRIVE) && (held < limit);

    assign o_wr_en   = push;
    assign o_wr_ptr  = r_tail;
    assign o_wr_data = {i_pkt_duration, i_pkt_tag};
    assign o_rd_en   = acc;
    assign o_rd_ptr  = r_head;

    assign f_exp = r_fstamp_vld && (i_now_ms >= r_fstamp)
                   && ((i_now_ms - r_fstamp) > i_cfg.flow_hold);
    assign c_exp = r_cstamp_vld && (i_now_ms >= r_cstamp)
                   && ((i_now_ms - r_cstamp) > i_cfg.congestion_hold);
    assign flow_sum = {1'b0, r_flow} + {{(TIME_W-15){1'b0}}, i_cfg.flow_step};
    assign cong_sum = {1'b0, r_cong} + {{(TIME_W-15){1'b0}}, i_cfg.congestion_step};
    assign lag      = r_sent - i_rx_count;

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_flow       = r_flow;
        n_cong       = r_cong;
        n_fstamp     = r_fstamp;
        n_cstamp     = r_cstamp;
        n_fstamp_vld = r_fstamp_vld;
        n_cstamp_vld = r_cstamp_vld;
        n_sent       = r_sent;
        n_pend       = r_pend;
        n_s1.send       = 1'b0;
        n_s1.wake       = 1'b0;
        n_s1.dropped    = 1'b0;
        n_s1.now_ms     = i_now_ms;
        n_s1.flow_ms    = r_flow;
        n_s1.cong_delay = r_cong;
        unique case (cmd)
            CMD_EMERG: begin
                n_flow       = flow_sum[TIME_W] ? TIME_MAX : flow_sum[TIME_W-1:0];
                n_fstamp     = i_now_ms;
                n_fstamp_vld = 1'b1;
            end
            CMD_RXSTAT: begin
                if ((r_flow != '0) && (i_rx_fill < i_cfg.failsafe_fill)) begin
                    n_flow       = '0;
                    n_fstamp     = '0;
                    n_fstamp_vld = 1'b0;
                end
                if ((r_sent > i_rx_count)
                    && (lag > {{(TIME_W-16){1'b0}}, i_cfg.lag_tolerance})) begin
                    n_cstamp     = i_now_ms;
                    n_cstamp_vld = 1'b1;
                    n_cong       = cong_sum[TIME_W] ? TIME_MAX : cong_sum[TIME_W-1:0];
                end
            end
            CMD_SERVICE: begin
                if (c_exp) begin
                    n_cong = '0;
                end
                if (f_exp) begin
                    n_flow = '0;
                end
                if (r_count != '0) begin
                    n_head    = (r_head == LAST_PTR) ? '0 : r_head + PTR_W'(1);
                    n_count   = r_count - CNT_W'(1);
                    n_sent    = r_sent + TIME_W'(1);
                    n_pend    = 1'b1;
                    n_s1.send = 1'b1;
                    n_s1.wake = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            CMD_ARRIVE: begin
                if (c_exp) begin
                    n_cong = '0;
                end
                if (f_exp) begin
                    n_flow = '0;
                end
                if (!push) begin
                    n_s1.dropped = 1'b1;
                end else begin
                    n_tail  = (r_tail == LAST_PTR) ? '0 : r_tail + PTR_W'(1);
                    n_count = r_count + CNT_W'(1);
                    if (!r_pend) begin
                        n_pend    = 1'b1;
                        n_s1.wake = 1'b1;
                    end
                end
            end
            default: begin
                n_pend = r_pend;
            end
        endcase
        n_s1.flow_ms    = n_flow;
        n_s1.cong_delay = n_cong;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_flow       <= '0;
            r_cong       <= '0;
            r_fstamp     <= '0;
            r_cstamp     <= '0;
            r_fstamp_vld <= 1'b0;
            r_cstamp_vld <= 1'b0;
            r_sent       <= '0;
            r_pend       <= 1'b0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (acc) begin
                r_head       <= n_head;
                r_tail       <= n_tail;
                r_count      <= n_count;
                r_flow       <= n_flow;
                r_cong       <= n_cong;
                r_fstamp     <= n_fstamp;
                r_cstamp     <= n_cstamp;
                r_fstamp_vld <= n_fstamp_vld;
                r_cstamp_vld <= n_cstamp_vld;
                r_sent       <= n_sent;
                r_pend       <= n_pend;
                r_s1_valid   <= 1'b1;
            end else if (i_s1_free) begin
                r_s1_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1       <= n_s1;
            r_s1_count <= n_count;
        end
    end

endmodule

FILE: rtl/ftq_out.sv
// Wake time sum and output register of the transmit queue.
module ftq_out
    import ftq_pkg::*;
#(
    parameter int unsigned CNT_W = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s1_valid,
    input  t_s1                i_s1,
    input  logic [CNT_W-1:0]   i_s1_count,
    input  logic [ENTRY_W-1:0] i_rd_data,
    output logic               o_s1_free,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_send_valid,
    output logic [TAG_W-1:0]   o_send_tag,
    output logic               o_wake_valid,
    output logic [TIME_W-1:0]  o_wake_time,
    output logic               o_dropped,
    output logic [CNT_W-1:0]   o_queue_count
);

    logic              r_out_valid;
    logic              r_send_valid;
    logic [TAG_W-1:0]  r_send_tag;
    logic              r_wake_valid;
    logic [TIME_W-1:0] r_wake_time;
    logic              r_dropped;
    logic [CNT_W-1:0]  r_queue_count;

    logic [TIME_W+1:0] wake_sum;
    logic [TIME_W-1:0] n_wake_time;
    logic [TAG_W-1:0]  n_send_tag;

    assign o_s1_free     = !r_out_valid || i_out_ready;
    assign o_out_valid   = r_out_valid;
    assign o_send_valid  = r_send_valid;
    assign o_send_tag    = r_send_tag;
    assign o_wake_valid  = r_wake_valid;
    assign o_wake_time   = r_wake_time;
    assign o_dropped     = r_dropped;
    assign o_queue_count = r_queue_count;

    assign wake_sum = {2'b00, i_s1.now_ms}
                    + {{(TIME_W-14){1'b0}}, i_rd_data[ENTRY_W-1:TAG_W]}
                    + {2'b00, i_s1.flow_ms}
                    + {2'b00, i_s1.cong_delay};

    always_comb begin
        n_send_tag  = i_s1.send ? i_rd_data[TAG_W-1:0] : '0;
        n_wake_time = '0;
        if (i_s1.send) begin
            n_wake_time = (wake_sum[TIME_W+1:TIME_W] != 2'b00) ? TIME_MAX
                                                                 : wake_sum[TIME_W-1:0];
        end else if (i_s1.wake) begin
            n_wake_time = i_s1.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s1_free) begin
            r_out_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_free && i_s1_valid) begin
            r_send_valid  <= i_s1.send;
            r_send_tag    <= n_send_tag;
            r_wake_valid  <= i_s1.wake;
            r_wake_time   <= n_wake_time;
            r_dropped     <= i_s1.dropped;
            r_queue_count <= i_s1_count;
        end
    end

endmodule

FILE: rtl/feedback_paced_tx_queue_top.sv
// Top level of the feedback-paced transmit queue.
//
// Items enter on i_in_valid/o_in_ready: cmd selects packet arrival, service
// done, emergency feedback or receiver status; now_ms is the current time.
// Each item yields exactly one result on o_out_valid/i_out_ready carrying
// send, wake and drop flags, the sent tag, the requested wake time and the
// queue occupancy after the item.
// o_out_valid rises when an accepted item leaves the first stage, which
// updates pointers and delays and reads the head entry of the descriptor
// memory; the next stage adds the wake time and loads the output register.
// Throughput is one item per cycle unless the receiver stalls: every state
// update ends in stage one; an item needs at most one write and one read.
// Configuration is written on i_cfg_valid/o_cfg_ready with i_cfg_index and
// i_cfg_data; o_cfg_ready is always high. Write only while idle.
// Reset clears pointers, counts, delays and stamps and restores register
// defaults; the memory needs no clearing since only held entries are read.
// When the receiver stalls, the result holds in the output register, one
// more item can wait in the first stage, and o_in_ready then drops.
module feedback_paced_tx_queue_top
    import ftq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_cmd,
    input  logic [TIME_W-1:0]            i_now_ms,
    input  logic [TAG_W-1:0]             i_pkt_tag,
    input  logic [DUR_W-1:0]             i_pkt_duration,
    input  logic [TIME_W-1:0]            i_rx_count,
    input  logic [15:0]                  i_rx_fill,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_send_valid,
    output logic [TAG_W-1:0]             o_send_tag,
    output logic                         o_wake_valid,
    output logic [TIME_W-1:0]            o_wake_time,
    output logic                         o_dropped,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_queue_count,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cfg               cfg;
    t_s1                s1;
    logic               s1_valid;
    logic               s1_free;
    logic [CNT_W-1:0]   s1_count;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_ptr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_ptr;
    logic [ENTRY_W-1:0] rd_data;

    ftq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ftq_store #(
        .DEPTH (QUEUE_DEPTH),
        .PTR_W (PTR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_ptr  (wr_ptr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_ptr  (rd_ptr),
        .o_rd_data (rd_data)
    );

    ftq_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .PTR_W (PTR_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_now_ms       (i_now_ms),
        .i_pkt_tag      (i_pkt_tag),
        .i_pkt_duration (i_pkt_duration),
        .i_rx_count     (i_rx_count),
        .i_rx_fill      (i_rx_fill),
        .i_s1_free      (s1_free),
        .o_s1_valid     (s1_valid),
        .o_s1           (s1),
        .o_s1_count     (s1_count),
        .o_wr_en        (wr_en),
        .o_wr_ptr       (wr_ptr),
        .o_wr_data      (wr_data),
        .o_rd_en        (rd_en),
        .o_rd_ptr       (rd_ptr)
    );

    ftq_out #(
        .CNT_W (CNT_W)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s1_valid    (s1_valid),
        .i_s1          (s1),
        .i_s1_count    (s1_count),
        .i_rd_data     (rd_data),
        .o_s1_free     (s1_free),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_send_valid  (o_send_valid),
        .o_send_tag    (o_send_tag),
        .o_wake_valid  (o_wake_valid),
        .o_wake_time   (o_wake_time),
        .o_dropped     (o_dropped),
        .o_queue_count (o_queue_count)
    );

endmodule
